// ===== src/qpt_pkg.sv =====
// Package for the quantized probability table.
// Field widths, fixed-point constants, command codes and the control/status
// structs shared by the controller and the datapath. No dependencies.
package qpt_pkg;

  localparam int TID_W         = 10;
  localparam int PROB_W        = 25;
  localparam int FRAC_OUT_W    = 16;
  localparam int COUNT_W       = 11;
  localparam int SUPPORT_W     = 27;
  localparam int SUPPORT_OUT_W = 26;
  // Number of fraction bits in the Q24 probability format.
  localparam int PROB_FRAC_W   = 24;

  localparam logic [PROB_W-1:0] PROB_ONE = 25'd16777216;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } command_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic exec;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== src/qpt_if.sv =====
// Valid/ready channel interfaces for the quantized probability table.
// Depends on qpt_pkg for the field widths.
interface qpt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [qpt_pkg::TID_W-1:0]  tid;
  logic [qpt_pkg::PROB_W-1:0] probability;

  modport source (output valid, command, tid, probability, input ready);
  modport sink   (input valid, command, tid, probability, output ready);
endinterface

interface qpt_out_if;
  logic                              valid;
  logic                              ready;
  logic [qpt_pkg::FRAC_OUT_W-1:0]    fraction;
  logic                              already_present;
  logic [qpt_pkg::COUNT_W-1:0]       entry_count;
  logic [qpt_pkg::SUPPORT_OUT_W-1:0] support_total;

  modport source (output valid, fraction, already_present, entry_count, support_total,
                  input ready);
  modport sink   (input valid, fraction, already_present, entry_count, support_total,
                  output ready);
endinterface

// ===== src/qpt_ctrl.sv =====
// Controller of the quantized probability table: clearing pass after reset,
// word accept and execute sequencing. Depends on qpt_pkg.
module qpt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  qpt_pkg::dp_sts_t sts_i,
  output qpt_pkg::dp_cmd_t cmd_o
);
  import qpt_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        // Wait until the output register can take the new result word.
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/qpt_datapath.sv =====
// Datapath of the quantized probability table: presence and fraction
// memories, quantizer, count and support accumulators, output register.
// Depends on qpt_pkg.
module qpt_datapath #(
  parameter int ENTRIES       = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  qpt_pkg::dp_cmd_t                  cmd_i,
  output qpt_pkg::dp_sts_t                  sts_o,
  input  logic                              command_i,
  input  logic [qpt_pkg::TID_W-1:0]         tid_i,
  input  logic [qpt_pkg::PROB_W-1:0]        probability_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [qpt_pkg::FRAC_OUT_W-1:0]    fraction_o,
  output logic                              already_present_o,
  output logic [qpt_pkg::COUNT_W-1:0]       entry_count_o,
  output logic [qpt_pkg::SUPPORT_OUT_W-1:0] support_total_o
);
  import qpt_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int SHIFT = PROB_FRAC_W - FRACTION_BITS;

  logic                     pres_mem [ENTRIES];
  logic [FRACTION_BITS-1:0] frac_mem [ENTRIES];

  logic [IDX_W-1:0]         clr_cnt_q;
  logic [IDX_W-1:0]         addr, addr_q;
  logic                     in_range, in_range_q;
  logic                     command_q;
  logic [FRACTION_BITS-1:0] q_d, q_q;
  logic                     pres_rd_q;
  logic [FRACTION_BITS-1:0] frac_rd_q;

  logic [PROB_W-1:0]        p_m1;
  logic [PROB_FRAC_W-1:0]   p_shift;

  logic                     was_present, do_insert;
  logic [FRACTION_BITS-1:0] frac_after;

  logic [COUNT_W-1:0]       count_q;
  logic [SUPPORT_W-1:0]     support_q;
  logic                     out_valid_q;
  logic [FRAC_OUT_W-1:0]    fraction_q;
  logic                     already_q;

  assign addr     = IDX_W'(tid_i);
  assign in_range = (32'(tid_i) < 32'(ENTRIES));

  // The strict greater-than doubling yields the largest multiple of the
  // output step strictly below p, which is (p - 1) shifted down.
  assign p_m1    = probability_i - PROB_W'(1);
  assign p_shift = p_m1[PROB_FRAC_W-1:0] >> SHIFT;

  always_comb begin
    priority if (probability_i == '0) begin
      q_d = '0;
    end else if (probability_i >= PROB_ONE) begin
      q_d = '1;
    end else begin
      q_d = p_shift[FRACTION_BITS-1:0];
    end
  end

  assign was_present = in_range_q && pres_rd_q;
  assign do_insert   = in_range_q && (command_q == logic'(CMD_INSERT)) && !pres_rd_q;

  always_comb begin
    priority if (do_insert) begin
      frac_after = q_q;
    end else if (was_present) begin
      frac_after = frac_rd_q;
    end else begin
      frac_after = '0;
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == IDX_W'(ENTRIES - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Memories: registered reads on accept, writes on execute and, for the presence memory, on each clearing step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      pres_mem[clr_cnt_q] <= 1'b0;
    end else if (cmd_i.exec && do_insert) begin
      pres_mem[addr_q] <= 1'b1;
    end
    if (cmd_i.accept) begin
      pres_rd_q <= pres_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && do_insert) begin
      frac_mem[addr_q] <= q_q;
    end
    if (cmd_i.accept) begin
      frac_rd_q <= frac_mem[addr];
    end
  end

  // Captured input word and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q     <= addr;
      in_range_q <= in_range;
      command_q  <= command_i;
      q_q        <= q_d;
    end
    if (cmd_i.exec) begin
      fraction_q <= FRAC_OUT_W'(frac_after);
      already_q  <= was_present;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      count_q     <= '0;
      support_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      if (cmd_i.exec && do_insert) begin
        count_q   <= count_q + COUNT_W'(1);
        support_q <= support_q + SUPPORT_W'(q_q);
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Count and support change only together with a new result word, so the
  // output may show the live registers.
  assign out_valid_o       = out_valid_q;
  assign fraction_o        = fraction_q;
  assign already_present_o = already_q;
  assign entry_count_o     = count_q;
  assign support_total_o   = support_q[SUPPORT_OUT_W-1:0];

  a_exec_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> sts_o.out_free)
    else $error("result word loaded while the previous one is still pending");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.accept && cmd_i.exec) && !(cmd_i.clear_step && (cmd_i.accept || cmd_i.exec)))
    else $error("controller issued overlapping commands");

  a_no_insert_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && !do_insert) |=> ($stable(count_q) && $stable(support_q)))
    else $error("count or support changed without an insert");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && do_insert) |=> (count_q == COUNT_W'($past(count_q) + COUNT_W'(1))))
    else $error("insert did not advance the entry count by one");

endmodule

// ===== src/quantized_probability_table.sv =====
// Top level of the quantized probability table.
// Depends on qpt_pkg, qpt_if, qpt_ctrl and qpt_datapath.
//
//   channel | direction | handshake   | word fields
//   in_i    | sink      | valid/ready | command, tid, probability
//   out_o   | source    | valid/ready | fraction, already_present, entry_count, support_total
//
// Each word passes an accept step, which quantizes it and reads the table, and an
// execute step, which updates the table and loads the result; the registered memory
// read sets this split. After reset a clearing pass over the presence memory runs one
// entry at a time, with in_i.ready low.
// A result waits in the output register; the next word is accepted meanwhile and
// its execute cycle waits until out_o takes the pending word.
module quantized_probability_table #(
  parameter int ENTRIES       = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qpt_in_if.sink    in_i,
  qpt_out_if.source out_o
);
  import qpt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  qpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qpt_datapath #(
    .ENTRIES       (ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .command_i         (in_i.command),
    .tid_i             (in_i.tid),
    .probability_i     (in_i.probability),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .fraction_o        (out_o.fraction),
    .already_present_o (out_o.already_present),
    .entry_count_o     (out_o.entry_count),
    .support_total_o   (out_o.support_total)
  );

endmodule
